// ===== rtl/sgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sandpile grain drop package
// Shared constants and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sgd_pkg;

  localparam int SIDE_DEF = 64;
  localparam logic [6:0] SIDE_RST = 7'd50;

  localparam logic [2:0] TOPPLE_AT = 3'd4;

  localparam logic REQ_DROP = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Neighbor visiting order during a topple.
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_T_RD,
    ST_T_WR,
    ST_SW_RD,
    ST_SW_CHK,
    ST_NB_RD,
    ST_NB_WR,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/sgd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sandpile_grain_drop_top.sv =====
// ----------------------------------------------------------------------------
// Sandpile grain drop
// Abelian sandpile grid held in one RAM, with drop-and-relax and cell reads.
// ----------------------------------------------------------------------------
// After reset the block clears its height RAM, one entry per clock over all
// 2**(2*clog2(SIDE)) entries; no item is accepted until then. An
// out-of-range request goes from idle straight to the emit state, without
// touching the RAM. A read, or a drop that leaves the target below four
// grains, passes through the target read, target write, final read and final
// wait states before the emit state. A drop that starts an avalanche walks
// the active square in raster order, toppling every cell of four or more, and
// repeats the walk until one pass finds nothing to topple. Each cell visit
// reads the cell and then checks it, and each topple reads and writes every
// in-grid neighbor and skips each neighbor off the edge, all bound by the
// single read and single write port of the height RAM.
`default_nettype none

module sandpile_grain_drop_top #(
  parameter int SIDE = sgd_pkg::SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // row [5:0], col [11:6], zero [15:12]
  input  wire logic        s_tuser,   // req_type [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata    // topple_count [31:0], count_saturated [32],
                                      // cell_value [34:33], coord_error [35], zero [39:36]
);

  localparam int AW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int ADW   = 2 * AW;
  localparam int DEPTH = 2 ** ADW;
  localparam int SW    = ($clog2(SIDE + 1) > 7) ? $clog2(SIDE + 1) : 7;

  sgd_pkg::state_t state, state_next;

  logic [6:0]     side_in_use;
  logic [SW-1:0]  side_act;
  logic           req_type;
  logic [AW-1:0]  tgt_r, tgt_c, cur_r, cur_c;
  logic [1:0]     nb_k;
  logic           dirty;
  logic [31:0]    count;
  logic [ADW-1:0] clr_addr;
  logic [31:0]    res_count;
  logic [1:0]     res_cell;
  logic           res_err;

  logic           we;
  logic [ADW-1:0] waddr, raddr;
  logic [2:0]     wdata, rdata;

  logic           in_err;
  logic           last_col, last_row, sweep_end, advance;
  logic           nb_valid;
  logic [AW-1:0]  nb_r, nb_c;
  logic [ADW-1:0] tgt_addr, cur_addr, nb_addr;

  sgd_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_heights (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign side_act = (SW'(side_in_use) > SW'(SIDE)) ? SW'(SIDE) : SW'(side_in_use);
  assign in_err   = (SW'(s_tdata[5:0]) >= side_act) || (SW'(s_tdata[11:6]) >= side_act);

  assign tgt_addr = {tgt_r, tgt_c};
  assign cur_addr = {cur_r, cur_c};
  assign last_col = (SW'(cur_c) + SW'(1)) == side_act;
  assign last_row = (SW'(cur_r) + SW'(1)) == side_act;
  assign sweep_end = last_col && last_row;

  always_comb begin
    nb_r     = cur_r;
    nb_c     = cur_c;
    nb_valid = 1'b0;
    case (nb_k)
      sgd_pkg::NB_UP: begin
        nb_r     = cur_r - AW'(1);
        nb_valid = (cur_r != '0);
      end
      sgd_pkg::NB_DOWN: begin
        nb_r     = cur_r + AW'(1);
        nb_valid = !last_row;
      end
      sgd_pkg::NB_LEFT: begin
        nb_c     = cur_c - AW'(1);
        nb_valid = (cur_c != '0);
      end
      default: begin
        nb_c     = cur_c + AW'(1);
        nb_valid = !last_col;
      end
    endcase
  end
  assign nb_addr = {nb_r, nb_c};

  // Move on to the next cell of the sweep.
  always_comb begin
    case (state)
      sgd_pkg::ST_SW_CHK: advance = (rdata < sgd_pkg::TOPPLE_AT);
      sgd_pkg::ST_NB_RD:  advance = !nb_valid && (nb_k == sgd_pkg::NB_RIGHT);
      sgd_pkg::ST_NB_WR:  advance = (nb_k == sgd_pkg::NB_RIGHT);
      default:            advance = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sgd_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = sgd_pkg::ST_IDLE;
      end
      sgd_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = in_err ? sgd_pkg::ST_EMIT : sgd_pkg::ST_T_RD;
      end
      sgd_pkg::ST_T_RD: state_next = sgd_pkg::ST_T_WR;
      sgd_pkg::ST_T_WR: begin
        if (req_type == sgd_pkg::REQ_DROP && (rdata + 3'd1) >= sgd_pkg::TOPPLE_AT) begin
          state_next = sgd_pkg::ST_SW_RD;
        end else begin
          state_next = sgd_pkg::ST_FIN_RD;
        end
      end
      sgd_pkg::ST_SW_RD: state_next = sgd_pkg::ST_SW_CHK;
      sgd_pkg::ST_SW_CHK: begin
        if (rdata >= sgd_pkg::TOPPLE_AT) state_next = sgd_pkg::ST_NB_RD;
      end
      sgd_pkg::ST_NB_RD: begin
        if (nb_valid) state_next = sgd_pkg::ST_NB_WR;
      end
      sgd_pkg::ST_NB_WR:    state_next = sgd_pkg::ST_NB_RD;
      sgd_pkg::ST_FIN_RD:   state_next = sgd_pkg::ST_FIN_WAIT;
      sgd_pkg::ST_FIN_WAIT: state_next = sgd_pkg::ST_EMIT;
      sgd_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) state_next = sgd_pkg::ST_IDLE;
      end
      default: state_next = state;
    endcase
    if (advance) begin
      if (sweep_end && !dirty) state_next = sgd_pkg::ST_FIN_RD;
      else state_next = sgd_pkg::ST_SW_RD;
    end
  end

  always_comb begin
    s_tready = (state == sgd_pkg::ST_IDLE);
    we       = 1'b0;
    waddr    = tgt_addr;
    wdata    = rdata + 3'd1;
    raddr    = tgt_addr;
    case (state)
      sgd_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      sgd_pkg::ST_T_WR: begin
        we = (req_type == sgd_pkg::REQ_DROP);
      end
      sgd_pkg::ST_SW_RD: raddr = cur_addr;
      sgd_pkg::ST_SW_CHK: begin
        we    = (rdata >= sgd_pkg::TOPPLE_AT);
        waddr = cur_addr;
        wdata = rdata - sgd_pkg::TOPPLE_AT;
      end
      sgd_pkg::ST_NB_RD: raddr = nb_addr;
      sgd_pkg::ST_NB_WR: begin
        we    = 1'b1;
        waddr = nb_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sgd_pkg::ST_CLEAR;
      side_in_use <= sgd_pkg::SIDE_RST;
      clr_addr    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) side_in_use <= cfg_wdata;
      if (state == sgd_pkg::ST_CLEAR) clr_addr <= clr_addr + ADW'(1);
      if (state == sgd_pkg::ST_EMIT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sgd_pkg::ST_IDLE: begin
        req_type  <= s_tuser;
        tgt_r     <= AW'(s_tdata[5:0]);
        tgt_c     <= AW'(s_tdata[11:6]);
        res_err   <= in_err;
        res_cell  <= '0;
        res_count <= '0;
        count     <= '0;
        dirty     <= 1'b0;
        cur_r     <= '0;
        cur_c     <= '0;
      end
      sgd_pkg::ST_SW_CHK: begin
        if (rdata >= sgd_pkg::TOPPLE_AT) begin
          dirty <= 1'b1;
          nb_k  <= sgd_pkg::NB_UP;
          if (count != '1) count <= count + 32'd1;
        end
      end
      sgd_pkg::ST_NB_RD: begin
        if (!nb_valid) nb_k <= nb_k + 2'd1;
      end
      sgd_pkg::ST_NB_WR: nb_k <= nb_k + 2'd1;
      sgd_pkg::ST_FIN_WAIT: begin
        res_cell  <= rdata[1:0];
        res_count <= count;
      end
      sgd_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'd0, res_err, res_cell, (res_count == '1), res_count};
        end
      end
      default: ;
    endcase
    if (advance) begin
      if (sweep_end) begin
        cur_r <= '0;
        cur_c <= '0;
        dirty <= 1'b0;
      end else if (last_col) begin
        cur_c <= '0;
        cur_r <= cur_r + AW'(1);
      end else begin
        cur_c <= cur_c + AW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32] == (m_tdata[31:0] == 32'hFFFF_FFFF)))
    else $error("saturation flag disagrees with topple count");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[35]) |-> (m_tdata[34:0] == '0))
    else $error("coordinate error result carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    (state == sgd_pkg::ST_CLEAR) |-> !s_tready)
    else $error("item accepted during RAM clear");

  assert property (@(posedge clk) disable iff (rst)
    (state == sgd_pkg::ST_SW_CHK && rdata >= sgd_pkg::TOPPLE_AT) |=> dirty)
    else $error("topple did not mark the sweep dirty");

endmodule

`default_nettype wire
